### rtl/odf_pkg.sv
`default_nettype none
package odf_pkg;

    localparam int ODF_CORDIC_STEPS = 16;
    localparam int TAB_LEN          = 24;
    localparam int IT_W             = $clog2(TAB_LEN);
    localparam int ACC_W            = 66;
    localparam int PC_W             = 7;
    localparam int PADDR_W          = 4;

    // Input and result payloads
    typedef struct packed {
        logic               command;
        logic [31:0]        elapsed_ms;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [15:0] out_quat_w;
        logic signed [15:0] out_quat_x;
        logic signed [15:0] out_quat_y;
        logic signed [15:0] out_quat_z;
        logic               using_backup;
        logic [1:0]         status;
    } t_out_item;

    // Status codes
    localparam logic [1:0] ST_NORMAL    = 2'd0;
    localparam logic [1:0] ST_SWITCHED  = 2'd1;
    localparam logic [1:0] ST_NO_BACKUP = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_STARTUP = 2'd0;
    localparam logic [1:0] REG_JUMP    = 2'd1;
    localparam logic [1:0] REG_ACCUM   = 2'd2;

    // Operand file slots
    localparam logic [4:0] OP_Q  = 5'd0;
    localparam logic [4:0] OP_BQ = 5'd4;
    localparam logic [4:0] OP_OQ = 5'd8;
    localparam logic [4:0] OP_M  = 5'd12;
    localparam logic [4:0] OP_BP = 5'd21;
    localparam int         OPND_N = 24;

    // Microprogram segments
    localparam logic [PC_W-1:0] PC_YAW  = 7'd0;
    localparam logic [PC_W-1:0] PC_OFFQ = 7'd12;
    localparam logic [PC_W-1:0] PC_MAT  = 7'd28;
    localparam logic [PC_W-1:0] PC_ROT  = 7'd46;
    localparam logic [PC_W-1:0] PC_PUBQ = 7'd55;
    localparam logic [PC_W-1:0] PC_END  = 7'd71;

    // Quaternion product term signs, bit {row,term}
    localparam logic [15:0] QMUL_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

    // Writeback destination kinds
    typedef enum logic [3:0] {
        K_D, K_G, K_X, K_Y, K_OQ, K_M2, K_MONE, K_R, K_PQ
    } t_kind;

    typedef struct packed {
        logic  sub;
        logic  first;
        logic  last;
        t_kind kind;
        logic [3:0] idx;
    } t_mac_ctl;

    typedef struct packed {
        logic [4:0] a;
        logic [4:0] b;
        t_mac_ctl   ctl;
    } t_uop;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic [3:0] idx;
    } t_wb;

    // CORDIC angle table, 2^32 per turn
    function automatic logic [31:0] atan_at(input logic [IT_W-1:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic t_uop mk(input logic [4:0] a, input logic [4:0] b, input logic sub,
                                input logic first, input logic last, input t_kind kind,
                                input logic [3:0] idx);
        t_uop u;
        u.a = a;
        u.b = b;
        u.ctl.sub = sub;
        u.ctl.first = first;
        u.ctl.last = last;
        u.ctl.kind = kind;
        u.ctl.idx = idx;
        return u;
    endfunction

    // Microcode: one multiply-accumulate per entry
    function automatic t_uop uop_at(input logic [PC_W-1:0] pc);
        t_uop            u;
        logic [PC_W-1:0] off;
        logic [1:0]      k;
        logic [1:0]      j;
        logic [1:0]      a1, b1, a2, b2;
        logic            s2;
        logic            one;
        logic [1:0]      r;
        logic [1:0]      c;
        u = mk(OP_Q, OP_Q, 1'b0, 1'b0, 1'b0, K_D, 4'd0);
        off = '0;
        k = '0; j = '0; a1 = '0; b1 = '0; a2 = '0; b2 = '0; s2 = 1'b0; one = 1'b0;
        r = '0; c = '0;
        if (pc < PC_OFFQ) begin
            // norm, gimbal term, atan2 x and y terms
            unique case (pc[3:0])
                4'd0:  u = mk(OP_Q + 5'd0, OP_Q + 5'd0, 1'b0, 1'b1, 1'b0, K_D, 4'd0);
                4'd1:  u = mk(OP_Q + 5'd1, OP_Q + 5'd1, 1'b0, 1'b0, 1'b0, K_D, 4'd0);
                4'd2:  u = mk(OP_Q + 5'd2, OP_Q + 5'd2, 1'b0, 1'b0, 1'b0, K_D, 4'd0);
                4'd3:  u = mk(OP_Q + 5'd3, OP_Q + 5'd3, 1'b0, 1'b0, 1'b1, K_D, 4'd0);
                4'd4:  u = mk(OP_Q + 5'd1, OP_Q + 5'd3, 1'b0, 1'b1, 1'b0, K_G, 4'd0);
                4'd5:  u = mk(OP_Q + 5'd0, OP_Q + 5'd2, 1'b1, 1'b0, 1'b1, K_G, 4'd0);
                4'd6:  u = mk(OP_Q + 5'd0, OP_Q + 5'd0, 1'b0, 1'b1, 1'b0, K_X, 4'd0);
                4'd7:  u = mk(OP_Q + 5'd1, OP_Q + 5'd1, 1'b0, 1'b0, 1'b0, K_X, 4'd0);
                4'd8:  u = mk(OP_Q + 5'd2, OP_Q + 5'd2, 1'b1, 1'b0, 1'b0, K_X, 4'd0);
                4'd9:  u = mk(OP_Q + 5'd3, OP_Q + 5'd3, 1'b1, 1'b0, 1'b1, K_X, 4'd0);
                4'd10: u = mk(OP_Q + 5'd1, OP_Q + 5'd2, 1'b0, 1'b1, 1'b0, K_Y, 4'd0);
                4'd11: u = mk(OP_Q + 5'd0, OP_Q + 5'd3, 1'b0, 1'b0, 1'b1, K_Y, 4'd0);
                default: u = mk(OP_Q, OP_Q, 1'b0, 1'b0, 1'b0, K_D, 4'd0);
            endcase
        end else if (pc < PC_MAT) begin
            // q_primary * conj(q_backup)
            off = pc - PC_OFFQ;
            k = off[3:2];
            j = off[1:0];
            u = mk(OP_Q + {3'd0, j}, OP_BQ + {3'd0, j ^ k},
                   QMUL_NEG[{k, j}] ^ ((j ^ k) != 2'd0),
                   j == 2'd0, j == 2'd3, K_OQ, {2'd0, k});
        end else if (pc < PC_ROT) begin
            // rotation matrix of the offset quaternion, two products per entry
            off = pc - PC_MAT;
            unique case (off[4:1])
                4'd0: begin a1 = 2; b1 = 2; a2 = 3; b2 = 3; s2 = 0; one = 1; end
                4'd1: begin a1 = 1; b1 = 2; a2 = 0; b2 = 3; s2 = 1; one = 0; end
                4'd2: begin a1 = 1; b1 = 3; a2 = 0; b2 = 2; s2 = 0; one = 0; end
                4'd3: begin a1 = 1; b1 = 2; a2 = 0; b2 = 3; s2 = 0; one = 0; end
                4'd4: begin a1 = 1; b1 = 1; a2 = 3; b2 = 3; s2 = 0; one = 1; end
                4'd5: begin a1 = 2; b1 = 3; a2 = 0; b2 = 1; s2 = 1; one = 0; end
                4'd6: begin a1 = 1; b1 = 3; a2 = 0; b2 = 2; s2 = 1; one = 0; end
                4'd7: begin a1 = 2; b1 = 3; a2 = 0; b2 = 1; s2 = 0; one = 0; end
                default: begin a1 = 1; b1 = 1; a2 = 2; b2 = 2; s2 = 0; one = 1; end
            endcase
            if (!off[0]) begin
                u = mk(OP_OQ + {3'd0, a1}, OP_OQ + {3'd0, b1}, 1'b0, 1'b1, 1'b0,
                       one ? K_MONE : K_M2, off[4:1]);
            end else begin
                u = mk(OP_OQ + {3'd0, a2}, OP_OQ + {3'd0, b2}, s2, 1'b0, 1'b1,
                       one ? K_MONE : K_M2, off[4:1]);
            end
        end else if (pc < PC_PUBQ) begin
            // matrix times backup position, one row per three products
            off = pc - PC_ROT;
            if (off < 7'd3) begin
                r = 2'd0;
            end else if (off < 7'd6) begin
                r = 2'd1;
            end else begin
                r = 2'd2;
            end
            c = 2'(off - 7'(3 * r));
            u = mk(OP_M + 5'(off), OP_BP + {3'd0, c}, 1'b0, c == 2'd0, c == 2'd2,
                   K_R, {2'd0, r});
        end else begin
            // q_offset * q_backup
            off = pc - PC_PUBQ;
            k = off[3:2];
            j = off[1:0];
            u = mk(OP_OQ + {3'd0, j}, OP_BQ + {3'd0, j ^ k}, QMUL_NEG[{k, j}],
                   j == 2'd0, j == 2'd3, K_PQ, {2'd0, k});
        end
        return u;
    endfunction

    // Clamp a quaternion component to one in Q1.14
    function automatic logic signed [15:0] sat_q(input logic signed [19:0] v);
        logic signed [15:0] o;
        if (v > 20'sd16384) begin
            o = 16'sd16384;
        end else if (v < -20'sd16384) begin
            o = -16'sd16384;
        end else begin
            o = v[15:0];
        end
        return o;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        logic signed [31:0] o;
        if (v > 39'sh007FFFFFFF) begin
            o = 32'sh7FFFFFFF;
        end else if (v < -39'sh0080000000) begin
            o = 32'sh80000000;
        end else begin
            o = v[31:0];
        end
        return o;
    endfunction

endpackage
`default_nettype wire

### rtl/odf_in_if.sv
`default_nettype none
interface odf_in_if;
    import odf_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/odf_out_if.sv
`default_nettype none
interface odf_out_if;
    import odf_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/odf_mac.sv
`default_nettype none
module odf_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_issue,
    input  logic signed [31:0]               i_a,
    input  logic signed [31:0]               i_b,
    input  odf_pkg::t_mac_ctl                i_ctl,
    output odf_pkg::t_wb                     o_wb,
    output logic signed [odf_pkg::ACC_W-1:0] o_acc
);
    import odf_pkg::*;

    logic signed [63:0]      r_prod;
    logic                    r_v1;
    logic                    r_v2;
    t_mac_ctl                r_c1;
    t_mac_ctl                r_c2;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] w_ext;
    logic signed [ACC_W-1:0] w_base;

    // accumulate stage: start fresh or add to the running sum
    assign w_ext  = {{(ACC_W - 64){r_prod[63]}}, r_prod};
    assign w_base = r_c1.first ? '0 : r_acc;
    assign n_acc  = r_c1.sub ? (w_base - w_ext) : (w_base + w_ext);

    // valid tracking through product and sum stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
        end
    end

    // product register, then accumulator
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_c1   <= i_ctl;
        r_c2   <= r_c1;
        if (r_v1) begin
            r_acc <= n_acc;
        end
    end

    assign o_wb.valid = r_v2 & r_c2.last;
    assign o_wb.kind  = r_c2.kind;
    assign o_wb.idx   = r_c2.idx;
    assign o_acc      = r_acc;

endmodule
`default_nettype wire

### rtl/odometry_drift_failover.sv
// Odometry drift failover.
// Input channel i_in carries pose requests: command 0 is a primary sample, 1 a backup
// sample. Backup requests are stored on acceptance and give no result. Each primary
// request gives exactly one result on o_out.
// Primary path: a 12-entry multiply-accumulate program on one shared 32x32 multiplier
// forms the atan2 terms, then CORDIC_STEPS iterations of a shift-add unit give yaw.
// In backup mode a rotate (9 products) and a quaternion product (16 products) follow.
// The sample that switches over also computes the offset (16 + 18 + 9 products). All
// products run on the multiplier and its two-stage accumulate pipeline; i_in.ready is
// high only between requests.
// Results sit in an output register; the block takes the next request while a result
// waits, and holds the following result until o_out.ready frees the register.
// Reset (synchronous, i_rst_n low) loads the register defaults and clears the mode
// flags and yaw total. The APB port writes registers at 0x0, 0x4, 0x8; pready is tied
// high. Registers may only be written while no request is in progress.
`default_nettype none
module odometry_drift_failover #(
    parameter int CORDIC_STEPS = odf_pkg::ODF_CORDIC_STEPS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    odf_in_if.sink                       i_in,
    odf_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [odf_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import odf_pkg::*;

    localparam logic [IT_W-1:0] LAST_IT = IT_W'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RUN, S_DRAIN, S_YCHK, S_CORDIC, S_DECIDE, S_COMB_OFF, S_COMB_PUB, S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        SG_YAW, SG_OFFQ, SG_MAT, SG_ROT, SG_PUBQ
    } t_seg;

    // configuration
    logic [15:0] r_startup;
    logic [14:0] r_jump;
    logic [31:0] r_accum;

    // control state
    t_state          r_state;
    t_seg            r_seg;
    logic [PC_W-1:0] r_pc;
    logic            r_drain;
    logic            r_rot_off;
    logic [IT_W-1:0] r_it;
    logic            r_started;
    logic            r_active;
    logic            r_seen;
    logic [31:0]     r_total;
    logic            r_ovalid;

    // payload
    logic [15:0]        r_prev_yaw;
    logic [15:0]        r_yaw;
    logic [31:0]        r_elapsed;
    logic [1:0]         r_status;
    logic signed [31:0] r_p [3];
    logic signed [15:0] r_q [4];
    logic signed [31:0] r_bp [3];
    logic signed [15:0] r_bq [4];
    logic signed [31:0] r_op [3];
    logic signed [15:0] r_oq [4];
    logic signed [31:0] r_m [9];
    logic signed [37:0] r_r [3];
    logic signed [31:0] r_pub_p [3];
    logic signed [15:0] r_pub_q [4];
    logic signed [31:0] r_d, r_g, r_x, r_y;
    logic signed [34:0] r_cx, r_cy;
    logic [31:0]        r_ang;
    t_out_item          r_odata;

    // datapath wires
    t_uop                    w_uop;
    logic                    w_issue;
    logic signed [31:0]      w_opnd [OPND_N];
    logic signed [31:0]      w_a, w_b;
    t_wb                     w_wb;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [33:0]      w_r14;
    logic signed [ACC_W-1:0] w_r28;
    logic signed [15:0]      w_q14;
    logic [PC_W-1:0]         w_pc_last;
    logic                    w_cfg_wr;
    logic                    w_accept;
    logic [31:0]             w_gabs;
    logic                    w_yaw_zero;
    logic signed [34:0]      w_dx, w_dy;
    logic [31:0]             w_ang_nx;
    logic [31:0]             w_ang_rnd;
    logic [15:0]             w_diff;
    logic [16:0]             w_step;
    logic [32:0]             w_sum;
    logic [31:0]             w_total_nx;
    logic                    w_check;
    logic                    w_drift;
    logic                    w_switch;

    // shared multiply-accumulate unit
    odf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_issue),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_ctl   (w_uop.ctl),
        .o_wb    (w_wb),
        .o_acc   (w_acc)
    );

    // operand file
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_opnd[OP_Q + i]  = 32'(r_q[i]);
            w_opnd[OP_BQ + i] = 32'(r_bq[i]);
            w_opnd[OP_OQ + i] = 32'(r_oq[i]);
        end
        for (int i = 0; i < 9; i++) begin
            w_opnd[OP_M + i] = r_m[i];
        end
        for (int i = 0; i < 3; i++) begin
            w_opnd[OP_BP + i] = r_bp[i];
        end
    end

    assign w_uop   = uop_at(r_pc);
    assign w_issue = (r_state == S_RUN);
    assign w_a     = w_opnd[w_uop.a];
    assign w_b     = w_opnd[w_uop.b];

    // last program entry of the current segment
    always_comb begin
        unique case (r_seg)
            SG_YAW:  w_pc_last = PC_OFFQ - 7'd1;
            SG_OFFQ: w_pc_last = PC_MAT - 7'd1;
            SG_MAT:  w_pc_last = PC_ROT - 7'd1;
            SG_ROT:  w_pc_last = PC_PUBQ - 7'd1;
            default: w_pc_last = PC_END - 7'd1;
        endcase
    end

    // writeback rounding
    assign w_r14 = w_acc[33:0] + 34'sd8192;
    assign w_q14 = sat_q(w_r14[33:14]);
    assign w_r28 = w_acc + (ACC_W'(1) <<< 27);

    always_ff @(posedge i_clk) begin
        if (w_wb.valid) begin
            unique case (w_wb.kind)
                K_D:     r_d <= w_acc[31:0];
                K_G:     r_g <= w_acc[31:0];
                K_X:     r_x <= w_acc[31:0];
                K_Y:     r_y <= {w_acc[30:0], 1'b0};
                K_OQ:    r_oq[w_wb.idx[1:0]] <= w_q14;
                K_M2:    r_m[w_wb.idx] <= {w_acc[30:0], 1'b0};
                K_MONE:  r_m[w_wb.idx] <= 32'sd268435456 - {w_acc[30:0], 1'b0};
                K_R:     r_r[w_wb.idx[1:0]] <= w_r28[ACC_W-1:28];
                K_PQ:    r_pub_q[w_wb.idx[1:0]] <= w_q14;
                default: ;
            endcase
        end
    end

    // yaw special cases: zero norm, gimbal lock, both terms zero
    assign w_gabs     = r_g[31] ? (32'd0 - r_g) : r_g;
    assign w_yaw_zero = (r_d == 32'sd0) || ({1'b0, w_gabs, 1'b0} >= {2'b0, r_d})
                        || (r_x == 32'sd0 && r_y == 32'sd0);

    // CORDIC vectoring step
    assign w_dx      = r_cy >>> r_it;
    assign w_dy      = r_cx >>> r_it;
    assign w_ang_nx  = r_cy[34] ? (r_ang - atan_at(r_it)) : (r_ang + atan_at(r_it));
    assign w_ang_rnd = w_ang_nx + 32'h8000;

    // drift check
    assign w_diff     = r_yaw - r_prev_yaw;
    assign w_step     = w_diff[15] ? (17'h10000 - {1'b0, w_diff}) : {1'b0, w_diff};
    assign w_sum      = {1'b0, r_total} + {16'd0, w_step};
    assign w_total_nx = w_sum[32] ? 32'hFFFFFFFF : w_sum[31:0];
    assign w_check    = r_started && !r_active && (r_elapsed >= {16'd0, r_startup});
    assign w_drift    = (w_step > {2'd0, r_jump}) || (w_total_nx > r_accum);
    assign w_switch   = w_check && w_drift && r_seen;

    assign w_accept  = i_in.valid && (r_state == S_IDLE);
    assign i_in.ready = (r_state == S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seg     <= SG_YAW;
            r_pc      <= PC_YAW;
            r_drain   <= 1'b0;
            r_rot_off <= 1'b0;
            r_it      <= '0;
            r_started <= 1'b0;
            r_active  <= 1'b0;
            r_seen    <= 1'b0;
            r_total   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            // output register: load a new result or free it on acceptance
            if (r_state == S_EMIT && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in.data.command) begin
                            r_bp[0] <= i_in.data.pos_x;
                            r_bp[1] <= i_in.data.pos_y;
                            r_bp[2] <= i_in.data.pos_z;
                            r_bq[0] <= sat_q(20'(i_in.data.quat_w));
                            r_bq[1] <= sat_q(20'(i_in.data.quat_x));
                            r_bq[2] <= sat_q(20'(i_in.data.quat_y));
                            r_bq[3] <= sat_q(20'(i_in.data.quat_z));
                            r_seen  <= 1'b1;
                        end else begin
                            r_p[0]    <= i_in.data.pos_x;
                            r_p[1]    <= i_in.data.pos_y;
                            r_p[2]    <= i_in.data.pos_z;
                            r_q[0]    <= sat_q(20'(i_in.data.quat_w));
                            r_q[1]    <= sat_q(20'(i_in.data.quat_x));
                            r_q[2]    <= sat_q(20'(i_in.data.quat_y));
                            r_q[3]    <= sat_q(20'(i_in.data.quat_z));
                            r_elapsed <= i_in.data.elapsed_ms;
                            r_seg     <= SG_YAW;
                            r_pc      <= PC_YAW;
                            r_state   <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (r_pc == w_pc_last) begin
                        r_drain <= 1'b0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_pc <= r_pc + 7'd1;
                    end
                end
                S_DRAIN: begin
                    // wait for the last sum to reach its destination
                    r_drain <= 1'b1;
                    if (r_drain) begin
                        unique case (r_seg)
                            SG_YAW: r_state <= S_YCHK;
                            SG_OFFQ: begin
                                r_seg   <= SG_MAT;
                                r_pc    <= PC_MAT;
                                r_state <= S_RUN;
                            end
                            SG_MAT: begin
                                r_seg     <= SG_ROT;
                                r_pc      <= PC_ROT;
                                r_rot_off <= 1'b1;
                                r_state   <= S_RUN;
                            end
                            SG_ROT: r_state <= r_rot_off ? S_COMB_OFF : S_COMB_PUB;
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end
                S_YCHK: begin
                    r_it <= '0;
                    if (w_yaw_zero) begin
                        r_yaw   <= 16'd0;
                        r_state <= S_DECIDE;
                    end else begin
                        if (r_x[31]) begin
                            r_cx  <= 35'sd0 - 35'(r_x);
                            r_cy  <= 35'sd0 - 35'(r_y);
                            r_ang <= 32'h80000000;
                        end else begin
                            r_cx  <= 35'(r_x);
                            r_cy  <= 35'(r_y);
                            r_ang <= 32'h0;
                        end
                        r_state <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (r_cy[34]) begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                    end else begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                    end
                    r_ang <= w_ang_nx;
                    r_it  <= r_it + 1'b1;
                    if (r_it == LAST_IT) begin
                        r_yaw   <= w_ang_rnd[31:16];
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_started  <= 1'b1;
                    r_prev_yaw <= r_yaw;
                    if (w_check) begin
                        r_total <= w_total_nx;
                    end
                    if (w_check && w_drift) begin
                        r_status <= r_seen ? ST_SWITCHED : ST_NO_BACKUP;
                    end else begin
                        r_status <= ST_NORMAL;
                    end
                    if (w_switch) begin
                        r_seg   <= SG_OFFQ;
                        r_pc    <= PC_OFFQ;
                        r_state <= S_RUN;
                    end else if (r_active) begin
                        r_seg     <= SG_ROT;
                        r_pc      <= PC_ROT;
                        r_rot_off <= 1'b0;
                        r_state   <= S_RUN;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_COMB_OFF: begin
                    // offset position: primary minus rotated backup
                    for (int i = 0; i < 3; i++) begin
                        r_op[i] <= sat32({{7{r_p[i][31]}}, r_p[i]} - {r_r[i][37], r_r[i]});
                    end
                    r_active  <= 1'b1;
                    r_seg     <= SG_ROT;
                    r_pc      <= PC_ROT;
                    r_rot_off <= 1'b0;
                    r_state   <= S_RUN;
                end
                S_COMB_PUB: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pub_p[i] <= sat32({r_r[i][37], r_r[i]}
                                            + {{7{r_op[i][31]}}, r_op[i]});
                    end
                    r_seg   <= SG_PUBQ;
                    r_pc    <= PC_PUBQ;
                    r_state <= S_RUN;
                end
                S_EMIT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_odata.out_pos_x    <= r_active ? r_pub_p[0] : r_p[0];
                        r_odata.out_pos_y    <= r_active ? r_pub_p[1] : r_p[1];
                        r_odata.out_pos_z    <= r_active ? r_pub_p[2] : r_p[2];
                        r_odata.out_quat_w   <= r_active ? r_pub_q[0] : r_q[0];
                        r_odata.out_quat_x   <= r_active ? r_pub_q[1] : r_q[1];
                        r_odata.out_quat_y   <= r_active ? r_pub_q[2] : r_q[2];
                        r_odata.out_quat_z   <= r_active ? r_pub_q[3] : r_q[3];
                        r_odata.using_backup <= r_active;
                        r_odata.status       <= r_status;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup <= 16'd3000;
            r_jump    <= 15'd3650;
            r_accum   <= 32'd8344;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_STARTUP: r_startup <= pwdata[15:0];
                REG_JUMP:    r_jump    <= pwdata[14:0];
                REG_ACCUM:   r_accum   <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_STARTUP: prdata = {16'd0, r_startup};
            REG_JUMP:    prdata = {17'd0, r_jump};
            REG_ACCUM:   prdata = r_accum;
            default:     prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/odf_checker.sv
`default_nettype none
module odf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_command,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_using_backup,
    input logic [1:0] i_out_status
);
    import odf_pkg::*;

    // reset empties the output register
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a primary request keeps the block busy the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_in_command) |=> !i_in_ready)
        else $error("ready right after primary request");

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // switch status only with backup output, no-backup status only without
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_status == ST_SWITCHED) == i_out_using_backup ||
                         (i_out_status == ST_NORMAL && i_out_using_backup)))
        else $error("status disagrees with backup flag");

endmodule

bind odometry_drift_failover odf_checker u_odf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_command       (i_in.data.command),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_using_backup (o_out.data.using_backup),
    .i_out_status       (o_out.data.status)
);
`default_nettype wire
